// ===== rtl/adnp_pkg.sv =====
package adnp_pkg;

   localparam int CHAR_W      = 8;
   localparam int ACC_W       = 64;
   localparam int INT_MAG_W   = 63;
   localparam int FRAC_VAL_W  = 60;
   localparam int FRAC_CNT_W  = 5;
   localparam int CHAR_CNT_W  = 8;
   localparam int DIGIT_W     = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // register byte addresses
   localparam logic [CSR_ADDR_W-1:0] CSR_FRACTION_ENABLE = 3'd0;

   // character codes
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

   // largest accumulator value that can still take a digit
   localparam logic [ACC_W-1:0]     ACC_LIMIT = 64'd922337203685477580;
   localparam logic [INT_MAG_W-1:0] MAG_MAX   = {INT_MAG_W{1'b1}};
   localparam logic [DIGIT_W-1:0]   TOP_POS   = 4'd7;
   localparam logic [DIGIT_W-1:0]   TOP_NEG   = 4'd8;
   localparam logic [CHAR_CNT_W-1:0] CHAR_CNT_MAX = {CHAR_CNT_W{1'b1}};

   typedef enum logic [1:0] {
      PH_SPACE = 2'd0,
      PH_INT   = 2'd1,
      PH_FRAC  = 2'd2
   } phase_type;

   typedef struct packed {
      logic                  is_negative;
      logic [INT_MAG_W-1:0]  int_magnitude;
      logic [FRAC_VAL_W-1:0] frac_value;
      logic [FRAC_CNT_W-1:0] frac_count;
      logic [CHAR_CNT_W-1:0] chars_used;
      logic [CHAR_W-1:0]     end_char;
      logic                  ok;
   } rsp_type;

endpackage

// ===== rtl/adnp_req_if.sv =====
interface adnp_req_if;
   import adnp_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

// ===== rtl/adnp_rsp_if.sv =====
interface adnp_rsp_if;
   import adnp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  is_negative;
   logic [INT_MAG_W-1:0]  int_magnitude;
   logic [FRAC_VAL_W-1:0] frac_value;
   logic [FRAC_CNT_W-1:0] frac_count;
   logic [CHAR_CNT_W-1:0] chars_used;
   logic [CHAR_W-1:0]     end_char;
   logic                  ok;

   modport source (output valid, output is_negative, output int_magnitude,
                   output frac_value, output frac_count, output chars_used,
                   output end_char, output ok, input ready);
   modport sink   (input valid, input is_negative, input int_magnitude,
                   input frac_value, input frac_count, input chars_used,
                   input end_char, input ok, output ready);
endinterface

// ===== rtl/adnp_csr.sv =====
module adnp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [adnp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [adnp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [adnp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic                              fraction_enable
);
   import adnp_pkg::*;

   logic fraction_enable_ff;
   logic fraction_enable_in;
   logic hit;

   // word select: low two bits are the byte lane
   assign hit = (paddr[CSR_ADDR_W-1:2] == CSR_FRACTION_ENABLE[CSR_ADDR_W-1:2]);

   always_comb begin
      fraction_enable_in = fraction_enable_ff;
      if (psel && penable && pwrite && hit) begin
         fraction_enable_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fraction_enable_ff <= 1'b1;
      end else begin
         fraction_enable_ff <= fraction_enable_in;
      end
   end

   assign pready          = 1'b1;
   assign prdata          = hit ? {{(CSR_DATA_W-1){1'b0}}, fraction_enable_ff}
                                : '0;
   assign fraction_enable = fraction_enable_ff;
endmodule

// ===== rtl/adnp_parse.sv =====
module adnp_parse #(
   parameter int FRAC_DIGITS = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [adnp_pkg::CHAR_W-1:0]   char_in,
   input  logic                          fraction_enable,
   output logic                          terminate,
   output adnp_pkg::rsp_type             result
);
   import adnp_pkg::*;

   phase_type             phase_ff,   phase_in;
   logic                  neg_ff,     neg_in;
   logic [ACC_W-1:0]      acc_ff,     acc_in;
   logic [FRAC_VAL_W-1:0] frac_ff,    frac_in;
   logic [FRAC_CNT_W-1:0] fcnt_ff,    fcnt_in;
   logic [CHAR_CNT_W-1:0] ccnt_ff,    ccnt_in;
   logic                  ovf_ff,     ovf_in;

   logic                  is_digit, is_space, is_sign, is_point;
   logic                  in_space, in_lead, in_frac;
   logic                  take_space, take_sign, take_int, take_point, take_frac;
   logic [DIGIT_W-1:0]    digit;
   logic [DIGIT_W-1:0]    top;
   logic                  ovf_hit;
   logic [ACC_W-1:0]      acc_times_ten;
   logic [FRAC_VAL_W-1:0] frac_times_ten;

   assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
   assign is_space = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
   assign is_sign  = (char_in == CH_PLUS) || (char_in == CH_MINUS);
   assign is_point = (char_in == CH_POINT) && fraction_enable;
   assign digit    = char_in[DIGIT_W-1:0];

   assign in_space = (phase_ff == PH_SPACE);
   assign in_lead  = (phase_ff == PH_SPACE) || (phase_ff == PH_INT);
   assign in_frac  = (phase_ff == PH_FRAC);

   assign take_space = in_space && is_space;
   assign take_sign  = in_space && is_sign;
   assign take_int   = in_lead && is_digit;
   assign take_point = in_lead && is_point;
   assign take_frac  = in_frac && is_digit;
   assign terminate  = !(take_space || take_sign || take_int || take_point || take_frac);

   // x*10 as x*8 + x*2, digit added in
   assign acc_times_ten  = {acc_ff[ACC_W-4:0], 3'b000} + {acc_ff[ACC_W-2:0], 1'b0}
                         + {{(ACC_W-DIGIT_W){1'b0}}, digit};
   assign frac_times_ten = {frac_ff[FRAC_VAL_W-4:0], 3'b000}
                         + {frac_ff[FRAC_VAL_W-2:0], 1'b0}
                         + {{(FRAC_VAL_W-DIGIT_W){1'b0}}, digit};

   assign top     = neg_ff ? TOP_NEG : TOP_POS;
   assign ovf_hit = (acc_ff > ACC_LIMIT) || ((acc_ff == ACC_LIMIT) && (digit > top));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_SPACE: begin
            if (take_sign || take_int) begin
               phase_in = PH_INT;
            end else if (take_point) begin
               phase_in = PH_FRAC;
            end
         end
         PH_INT: begin
            if (terminate) begin
               phase_in = PH_SPACE;
            end else if (take_point) begin
               phase_in = PH_FRAC;
            end
         end
         PH_FRAC: begin
            if (terminate) begin
               phase_in = PH_SPACE;
            end
         end
         default: begin
            phase_in = PH_SPACE;
         end
      endcase
   end

   // number fields
   always_comb begin
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      frac_in = frac_ff;
      fcnt_in = fcnt_ff;
      ccnt_in = ccnt_ff;
      ovf_in  = ovf_ff;
      if (terminate) begin
         neg_in  = 1'b0;
         acc_in  = '0;
         frac_in = '0;
         fcnt_in = '0;
         ccnt_in = '0;
         ovf_in  = 1'b0;
      end else begin
         if (ccnt_ff != CHAR_CNT_MAX) begin
            ccnt_in = ccnt_ff + 1'b1;
         end
         if (take_sign) begin
            neg_in = (char_in == CH_MINUS);
         end
         if (take_int && !ovf_ff) begin
            if (ovf_hit) begin
               ovf_in = 1'b1;
            end else begin
               acc_in = acc_times_ten;
            end
         end
         if (take_frac && (fcnt_ff < FRAC_CNT_W'(FRAC_DIGITS))) begin
            frac_in = frac_times_ten;
            fcnt_in = fcnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         frac_ff  <= '0;
         fcnt_ff  <= '0;
         ccnt_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         frac_ff  <= frac_in;
         fcnt_ff  <= fcnt_in;
         ccnt_ff  <= ccnt_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_comb begin
      result.is_negative   = neg_ff;
      result.int_magnitude = ovf_ff ? '0 : (acc_ff[ACC_W-1] ? MAG_MAX : acc_ff[INT_MAG_W-1:0]);
      result.frac_value    = ovf_ff ? '0 : frac_ff;
      result.frac_count    = ovf_ff ? '0 : fcnt_ff;
      result.chars_used    = ccnt_ff;
      result.end_char      = char_in;
      result.ok            = !ovf_ff;
   end
endmodule

// ===== rtl/adnp_out.sv =====
module adnp_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  adnp_pkg::rsp_type result,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output adnp_pkg::rsp_type rsp_data,
   output logic              free
);
   import adnp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule

// ===== rtl/ascii_decimal_number_parser_core.sv =====
// channel   | dir | handshake          | word
// ----------+-----+--------------------+-------------------------------------------
// req_word  | in  | valid/ready        | char_in
// rsp_word  | out | valid/ready        | is_negative, int_magnitude, frac_value,
//           |     |                    | frac_count, chars_used, end_char, ok
// csr_*     | in  | apb, pready tied 1 | fraction_enable at byte address 0
//
// one character a cycle unless a terminator waits on a full result register; a character
// is registered, then parsed, and a terminator drops its number into the result register
// the parse state (accumulators, counters, phase) is the loop that sets the character rate:
// each step is one shift-add by ten and one compare against the overflow limit
// reset is synchronous and active high; it clears the parse state and sets fraction_enable
// a terminator waits in the input register while the result register holds an untaken word;
// characters taken into a number (leading space, sign, digit, enabled point) never wait
module ascii_decimal_number_parser_core #(
   parameter int FRAC_DIGITS = 18
) (
   input  logic                              clock,
   input  logic                              reset,
   adnp_req_if.sink                          req_word,
   adnp_rsp_if.source                        rsp_word,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [adnp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [adnp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [adnp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import adnp_pkg::*;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;

   logic    fraction_enable;
   logic    terminate;
   logic    out_free;
   logic    advance;
   logic    accept;
   rsp_type result;
   rsp_type rsp_data;

   adnp_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (csr_psel),
      .penable         (csr_penable),
      .pwrite          (csr_pwrite),
      .paddr           (csr_paddr),
      .pwdata          (csr_pwdata),
      .prdata          (csr_prdata),
      .pready          (csr_pready),
      .fraction_enable (fraction_enable)
   );

   // the held character moves on unless it ends a number and the result slot is busy
   assign advance = in_valid_ff && (!terminate || out_free);
   assign accept  = req_word.valid && req_word.ready;
   assign req_word.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_word.char_in;
      end
   end

   adnp_parse #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_parse (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .char_in         (in_char_ff),
      .fraction_enable (fraction_enable),
      .terminate       (terminate),
      .result          (result)
   );

   // result register parts the parser from the consumer
   adnp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && terminate),
      .result    (result),
      .rsp_ready (rsp_word.ready),
      .rsp_valid (rsp_word.valid),
      .rsp_data  (rsp_data),
      .free      (out_free)
   );

   assign rsp_word.is_negative   = rsp_data.is_negative;
   assign rsp_word.int_magnitude = rsp_data.int_magnitude;
   assign rsp_word.frac_value    = rsp_data.frac_value;
   assign rsp_word.frac_count    = rsp_data.frac_count;
   assign rsp_word.chars_used    = rsp_data.chars_used;
   assign rsp_word.end_char      = rsp_data.end_char;
   assign rsp_word.ok            = rsp_data.ok;
endmodule
